// ===== rtl/lerect_pkg.sv =====
// Shared types and constants for the largest empty rectangle finder.
`default_nettype none

package lerect_pkg;

  // Fixed field widths of the channels.
  localparam int CELL_W      = 8;
  localparam int AREA_W      = 13;
  localparam int DIM_W       = 7;
  localparam int POS_W       = 6;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  // Reset value of both grid size registers.
  localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_FLUSH,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/largest_empty_rectangle.sv =====
// Top level of the largest empty rectangle finder over an occupancy grid.
//
// Usage: the cells of a grid arrive on the cell channel (cell_valid,
// cell_stall, cell_value) in row-major order, one cell per transfer; zero
// means free. After the last cell of a grid one result transfer leaves on
// the result channel (result_valid, result_stall, best_*) with the area,
// size and top-left corner of the largest free rectangle, all zero when no
// cell is free. The first rectangle of the largest area in scan order wins.
// Grid size is set through the cfg channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data); a size write restarts the current grid. cfg_ready is always high.
//
// Sequence: ST_IDLE takes a cell, then ST_POP pops every stack entry
// taller than its column and pushes the column. ST_FLUSH pops all entries
// left at the end of a row, and ST_EMIT loads the result register at the
// end of a grid. The sweep makes one push or one pop per cycle.
// Column heights live in a memory that is read ahead for the next column.
//
// Reset brings the grid size to 64 by 64 and starts a fresh grid; no
// clearing pass is needed because row zero ignores the height memory.
// The result sits in an output register, so cells keep flowing while a
// result is stalled; only a second result waits until the first is taken.
`default_nettype none

module largest_empty_rectangle #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cell_valid,
  output logic                                cell_stall,
  input  logic [lerect_pkg::CELL_W-1:0]       cell_value,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [lerect_pkg::AREA_W-1:0]       best_area,
  output logic [lerect_pkg::DIM_W-1:0]        best_width,
  output logic [lerect_pkg::DIM_W-1:0]        best_height,
  output logic [lerect_pkg::POS_W-1:0]        best_x,
  output logic [lerect_pkg::POS_W-1:0]        best_y,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lerect_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lerect_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import lerect_pkg::*;

  // Column index, column count, height, row index, stack depth widths.
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int DW = $clog2(MAX_WIDTH + 1);
  localparam int YW = HW + 1;
  localparam int SW = CW + HW;
  localparam int AW = WW + HW;

  state_t state, state_next;

  logic [CFG_DATA_W-1:0] grid_width, grid_width_next;
  logic [CFG_DATA_W-1:0] grid_height, grid_height_next;
  logic [CW-1:0]         column_index, column_index_next;
  logic [RW-1:0]         row_index, row_index_next;
  logic [DW-1:0]         stack_depth, stack_depth_next;
  logic                  pend, pend_next;
  logic                  h_ok;
  logic [CW-1:0]         top_start, top_start_next;
  logic [HW-1:0]         top_height, top_height_next;
  logic [CW-1:0]         start_acc, start_acc_next;
  logic [HW-1:0]         h_cur, h_cur_next;
  logic [AW-1:0]         best_area_reg, best_area_reg_next;
  logic [WW-1:0]         best_width_reg, best_width_reg_next;
  logic [HW-1:0]         best_height_reg, best_height_reg_next;
  logic [CW-1:0]         best_x_reg, best_x_reg_next;
  logic [RW-1:0]         best_y_reg, best_y_reg_next;
  logic                  result_valid_next;
  logic                  load_result;

  logic [WW-1:0]         eff_w;
  logic [HW-1:0]         eff_h;

  // Memory ports.
  logic                  col_we;
  logic [HW-1:0]         col_wdata;
  logic [HW-1:0]         col_rdata;
  logic                  stk_we;
  logic [CW-1:0]         stk_waddr;
  logic [SW-1:0]         stk_wdata;
  logic [CW-1:0]         stk_raddr;
  logic [SW-1:0]         stk_rdata;

  // Sweep datapath.
  logic                  accept;
  logic                  cfg_we;
  logic                  slot_free;
  logic [CW-1:0]         top_s_eff;
  logic [HW-1:0]         top_h_eff;
  logic [WW-1:0]         sweep_col;
  logic [HW-1:0]         sweep_h;
  logic                  pop_go;
  logic [WW-1:0]         span_w;
  logic [AW-1:0]         cand_area;
  logic [YW-1:0]         cand_y;
  logic [HW-1:0]         base_h;
  logic [HW-1:0]         new_h;
  logic [DW-1:0]         depth_m2;

  assign cfg_ready  = 1'b1;
  assign cfg_we     = cfg_valid && cfg_ready;
  assign cell_stall = !((state == ST_IDLE) && h_ok);
  assign accept     = cell_valid && !cell_stall;
  assign slot_free  = !result_valid || !result_stall;

  // Size registers are clamped to the range the storage supports.
  always_comb begin
    if (grid_width == '0) begin
      eff_w = WW'(1);
    end else if (int'(grid_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(grid_width);
    end
    if (grid_height == '0) begin
      eff_h = HW'(1);
    end else if (int'(grid_height) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(grid_height);
    end
  end

  // The column height memory holds the run of free cells ending at the
  // previous row. Row zero of a grid ignores it, which stands in for a clear.
  lerect_ram #(
    .WIDTH (HW),
    .DEPTH (MAX_WIDTH)
  ) u_col_mem (
    .clk     (clk),
    .wr_en   (col_we),
    .wr_addr (column_index),
    .wr_data (col_wdata),
    .rd_addr (column_index_next),
    .rd_data (col_rdata)
  );

  // The stack memory holds every entry; the entry last pushed is also cached
  // in top_start and top_height. After a pop the new top arrives from the
  // registered memory read in the next cycle and pend selects it.
  lerect_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_WIDTH)
  ) u_stack_mem (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  assign top_s_eff = pend ? stk_rdata[SW-1:HW] : top_start;
  assign top_h_eff = pend ? stk_rdata[HW-1:0] : top_height;

  // The end-of-row flush sweeps a zero-height column just past the grid.
  assign sweep_col = (state == ST_FLUSH) ? eff_w : WW'(column_index);
  assign sweep_h   = (state == ST_FLUSH) ? '0 : h_cur;
  assign pop_go    = (stack_depth != '0) && (top_h_eff > sweep_h);

  assign span_w    = sweep_col - WW'(top_s_eff);
  assign cand_area = AW'(span_w) * AW'(top_h_eff);
  assign cand_y    = YW'(row_index) + YW'(1) - YW'(top_h_eff);
  assign depth_m2  = stack_depth - DW'(2);

  // New height of the current column: one more than above if free, with
  // saturation at the largest height, or zero if occupied.
  assign base_h = (row_index == '0) ? '0 : col_rdata;
  always_comb begin
    if (cell_value == '0) begin
      if (base_h < HW'(MAX_HEIGHT)) begin
        new_h = base_h + HW'(1);
      end else begin
        new_h = base_h;
      end
    end else begin
      new_h = '0;
    end
  end

  always_comb begin
    state_next           = state;
    grid_width_next      = grid_width;
    grid_height_next     = grid_height;
    column_index_next    = column_index;
    row_index_next       = row_index;
    stack_depth_next     = stack_depth;
    pend_next            = pend;
    top_start_next       = top_start;
    top_height_next      = top_height;
    start_acc_next       = start_acc;
    h_cur_next           = h_cur;
    best_area_reg_next   = best_area_reg;
    best_width_reg_next  = best_width_reg;
    best_height_reg_next = best_height_reg;
    best_x_reg_next      = best_x_reg;
    best_y_reg_next      = best_y_reg;
    load_result          = 1'b0;
    col_we               = 1'b0;
    col_wdata            = new_h;
    stk_we               = 1'b0;
    stk_waddr            = stack_depth[CW-1:0];
    stk_wdata            = {start_acc, h_cur};
    stk_raddr            = depth_m2[CW-1:0];

    result_valid_next = result_valid && result_stall;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          col_we         = 1'b1;
          h_cur_next     = new_h;
          start_acc_next = column_index;
          if (column_index == '0) begin
            stack_depth_next = '0;
            pend_next        = 1'b0;
          end
          state_next = ST_POP;
        end
      end

      ST_POP, ST_FLUSH: begin
        if (pop_go) begin
          // Pop one entry and weigh the rectangle it closes.
          if (cand_area > best_area_reg) begin
            best_area_reg_next   = cand_area;
            best_width_reg_next  = span_w;
            best_height_reg_next = top_h_eff;
            best_x_reg_next      = top_s_eff;
            best_y_reg_next      = cand_y[RW-1:0];
          end
          stack_depth_next = stack_depth - DW'(1);
          pend_next        = (stack_depth != DW'(1));
          start_acc_next   = top_s_eff;
        end else if (state == ST_POP) begin
          // Push the current column with the leftmost start it reaches.
          stk_we           = 1'b1;
          top_start_next   = start_acc;
          top_height_next  = h_cur;
          stack_depth_next = stack_depth + DW'(1);
          pend_next        = 1'b0;
          if (WW'(column_index) + WW'(1) < eff_w) begin
            column_index_next = column_index + CW'(1);
            state_next        = ST_IDLE;
          end else begin
            state_next = ST_FLUSH;
          end
        end else begin
          // Row finished: the stack is empty again.
          stack_depth_next  = '0;
          pend_next         = 1'b0;
          column_index_next = '0;
          if (HW'(row_index) + HW'(1) < eff_h) begin
            row_index_next = row_index + RW'(1);
            state_next     = ST_IDLE;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          load_result          = 1'b1;
          result_valid_next    = 1'b1;
          best_area_reg_next   = '0;
          best_width_reg_next  = '0;
          best_height_reg_next = '0;
          best_x_reg_next      = '0;
          best_y_reg_next      = '0;
          row_index_next       = '0;
          state_next           = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // A size write abandons the grid in progress.
    if (cfg_we && ((cfg_index == REG_GRID_WIDTH) || (cfg_index == REG_GRID_HEIGHT))) begin
      if (cfg_index == REG_GRID_WIDTH) begin
        grid_width_next = cfg_data;
      end else begin
        grid_height_next = cfg_data;
      end
      state_next           = ST_IDLE;
      column_index_next    = '0;
      row_index_next       = '0;
      stack_depth_next     = '0;
      pend_next            = 1'b0;
      best_area_reg_next   = '0;
      best_width_reg_next  = '0;
      best_height_reg_next = '0;
      best_x_reg_next      = '0;
      best_y_reg_next      = '0;
      load_result          = 1'b0;
      result_valid_next    = result_valid && result_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      grid_width      <= GRID_SIZE_RESET;
      grid_height     <= GRID_SIZE_RESET;
      column_index    <= '0;
      row_index       <= '0;
      stack_depth     <= '0;
      pend            <= 1'b0;
      h_ok            <= 1'b0;
      best_area_reg   <= '0;
      best_width_reg  <= '0;
      best_height_reg <= '0;
      best_x_reg      <= '0;
      best_y_reg      <= '0;
      result_valid    <= 1'b0;
    end else begin
      state           <= state_next;
      grid_width      <= grid_width_next;
      grid_height     <= grid_height_next;
      column_index    <= column_index_next;
      row_index       <= row_index_next;
      stack_depth     <= stack_depth_next;
      pend            <= pend_next;
      // The height read issued this cycle is good once the block idles.
      h_ok            <= (state_next == ST_IDLE);
      best_area_reg   <= best_area_reg_next;
      best_width_reg  <= best_width_reg_next;
      best_height_reg <= best_height_reg_next;
      best_x_reg      <= best_x_reg_next;
      best_y_reg      <= best_y_reg_next;
      result_valid    <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    top_start  <= top_start_next;
    top_height <= top_height_next;
    start_acc  <= start_acc_next;
    h_cur      <= h_cur_next;
    if (load_result) begin
      best_area   <= AREA_W'(best_area_reg);
      best_width  <= DIM_W'(best_width_reg);
      best_height <= DIM_W'(best_height_reg);
      best_x      <= POS_W'(best_x_reg);
      best_y      <= POS_W'(best_y_reg);
    end
  end

  // The stack never holds more entries than MAX_WIDTH.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    stack_depth <= DW'(MAX_WIDTH))
    else $error("stack depth beyond row width");

  // A cell transfer with no cfg write beside it starts a stack sweep.
  a_accept_pops: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_we |=> state == ST_POP)
    else $error("accepted cell did not start a sweep");

  // While waiting for a cell, the column position lies inside the grid.
  a_column_in_grid: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> WW'(column_index) < eff_w)
    else $error("column index outside grid");

  // The result waits with an empty stack, and appears only from that wait.
  a_emit_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> stack_depth == '0)
    else $error("stack not flushed at end of grid");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_EMIT)
    else $error("result raised outside end of grid");

endmodule

`default_nettype wire

// ===== rtl/lerect_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none

module lerect_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire
